@@ sv/dvdd_pkg.sv @@
// dvdd_pkg: shared types, constants and calendar tables for the day difference block
// no dependencies

package dvdd_pkg;

    localparam int unsigned DayW   = 5;
    localparam int unsigned MonthW = 4;
    localparam int unsigned YearW  = 14;
    localparam int unsigned CountW = 22;
    localparam int unsigned QuotW  = 8;   // year / 100 for a 14-bit year
    localparam int unsigned RemW   = 7;   // year % 100

    // x / 100 == (x * Recip100) >> Recip100Shift for every 14-bit x
    localparam int unsigned Recip100      = 5243;
    localparam int unsigned Recip100W     = 13;
    localparam int unsigned Recip100Shift = 19;
    localparam int unsigned ProdW         = YearW + Recip100W;

    localparam logic [YearW-1:0] YearMin = YearW'(1);
    localparam logic [YearW-1:0] YearMax = YearW'(9999);

    localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
    localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
    localparam logic [MonthW-1:0] MonthDec = MonthW'(12);

    localparam logic [DayW-1:0] FebLeapLen = DayW'(29);

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FIRST_BAD  = 2'd1,
        STATUS_SECOND_BAD = 2'd2,
        STATUS_BACKWARD   = 2'd3
    } dvdd_status_t;

    // per-stage load enables of the date pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } dvdd_adv_t;

    // length of a common-year month, zero for a month code outside 1..12
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
        logic [DayW-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days in a common year before the first of the month
    function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

@@ sv/dvdd_date_unit.sv @@
// dvdd_date_unit: three-stage pipeline that checks one date and forms its ordinal day number
// depends on dvdd_pkg

module dvdd_date_unit
    import dvdd_pkg::*;
(
    input  logic              aclk,
    input  dvdd_adv_t         adv,
    input  logic [DayW-1:0]   day,
    input  logic [MonthW-1:0] month,
    input  logic [YearW-1:0]  year,
    output logic              date_ok,
    output logic [CountW-1:0] ordinal
);

    // stage 1: year / 100 by reciprocal multiply
    logic [DayW-1:0]   s1_day_reg;
    logic [MonthW-1:0] s1_month_reg;
    logic [YearW-1:0]  s1_year_reg;
    logic [QuotW-1:0]  s1_q100_reg, s1_q100_next;
    logic [ProdW-1:0]  s1_prod;

    assign s1_prod      = ProdW'(year) * ProdW'(Recip100);
    assign s1_q100_next = s1_prod[ProdW-1 -: QuotW];

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            s1_day_reg   <= day;
            s1_month_reg <= month;
            s1_year_reg  <= year;
            s1_q100_reg  <= s1_q100_next;
        end
    end

    // stage 2: leap rule, range checks, (year-1) / 100
    logic [DayW-1:0]   s2_day_reg;
    logic [MonthW-1:0] s2_month_reg;
    logic [YearW-1:0]  s2_py_reg, s2_py_next;
    logic [QuotW-1:0]  s2_pq_reg, s2_pq_next;
    logic              s2_leap_reg, s2_leap_next;
    logic              s2_ok_reg, s2_ok_next;
    logic [YearW-1:0]  s2_hundreds;
    logic [RemW-1:0]   s2_rem;
    logic              s2_rem_zero;
    logic [DayW-1:0]   s2_limit;

    always_comb begin
        s2_hundreds  = YearW'(s1_q100_reg) * YearW'(100);
        s2_rem       = RemW'(s1_year_reg - s2_hundreds);
        s2_rem_zero  = (s2_rem == '0);
        s2_leap_next = (s1_year_reg[1:0] == 2'b00 && !s2_rem_zero)
                     || (s2_rem_zero && s1_q100_reg[1:0] == 2'b00);
        s2_pq_next   = s2_rem_zero ? s1_q100_reg - QuotW'(1) : s1_q100_reg;
        s2_py_next   = s1_year_reg - YearW'(1);
        s2_limit     = month_len(s1_month_reg);
        if (s1_month_reg == MonthFeb && s2_leap_next) begin
            s2_limit = FebLeapLen;
        end
        s2_ok_next   = (s1_year_reg >= YearMin) && (s1_year_reg <= YearMax)
                     && (s1_month_reg >= MonthJan) && (s1_month_reg <= MonthDec)
                     && (s1_day_reg != '0) && (s1_day_reg <= s2_limit);
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            s2_day_reg   <= s1_day_reg;
            s2_month_reg <= s1_month_reg;
            s2_py_reg    <= s2_py_next;
            s2_pq_reg    <= s2_pq_next;
            s2_leap_reg  <= s2_leap_next;
            s2_ok_reg    <= s2_ok_next;
        end
    end

    // stage 3: ordinal = 365*py + py/4 - py/100 + py/400 + month offset + leap day + day
    localparam int unsigned SumW = CountW + 1;
    logic [SumW-1:0]   s3_sum;
    logic [CountW-1:0] s3_ord_reg;
    logic              s3_ok_reg;

    always_comb begin
        s3_sum = SumW'(s2_py_reg) * SumW'(365)
               + SumW'(s2_py_reg >> 2)
               - SumW'(s2_pq_reg)
               + SumW'(s2_pq_reg >> 2)
               + SumW'(days_before(s2_month_reg))
               + SumW'(s2_leap_reg && s2_month_reg > MonthFeb)
               + SumW'(s2_day_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            s3_ord_reg <= s3_sum[CountW-1:0];
            s3_ok_reg  <= s2_ok_reg;
        end
    end

    assign date_ok = s3_ok_reg;
    assign ordinal = s3_ord_reg;

endmodule

@@ sv/date_validate_day_difference.sv @@
// date_validate_day_difference: top level, two date pipelines, compare stage and flow control
// depends on dvdd_pkg and dvdd_date_unit
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------------------
//  s_      | in        | s_valid / s_ready | first/second day, month, year
//  m_      | out       | m_valid / m_ready | m_status, m_day_count
//
// four register stages; an item is registered in stages 1 to 4 in turn and m_valid is the
// stage 4 valid bit; one item per cycle sustained while m_ready stays high
// every stage holds a valid bit and loads when it is empty or its successor moves,
// so bubbles close up under a stall and an item enters while a result waits
// reset (aresetn low, synchronous) clears only the valid bits; data registers are not reset
// the four stages are: divide by 100, leap and range checks, ordinal sum, compare and subtract

module date_validate_day_difference
    import dvdd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DayW-1:0]   s_first_day,
    input  logic [MonthW-1:0] s_first_month,
    input  logic [YearW-1:0]  s_first_year,
    input  logic [DayW-1:0]   s_second_day,
    input  logic [MonthW-1:0] s_second_month,
    input  logic [YearW-1:0]  s_second_year,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [CountW-1:0] m_day_count
);

    // valid bits for each stage
    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      en4;
    dvdd_adv_t adv;

    // a stage moves when it is empty or its successor takes its item
    assign en4    = !v4_reg || m_ready;
    assign adv.s3 = !v3_reg || en4;
    assign adv.s2 = !v2_reg || adv.s3;
    assign adv.s1 = !v1_reg || adv.s2;
    assign s_ready = adv.s1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv.s1) v1_reg <= s_valid;
            if (adv.s2) v2_reg <= v1_reg;
            if (adv.s3) v3_reg <= v2_reg;
            if (en4)    v4_reg <= v3_reg;
        end
    end

    // the two dates run side by side through identical pipelines
    logic              first_ok, second_ok;
    logic [CountW-1:0] first_ord, second_ord;

    dvdd_date_unit u_first (
        .aclk    (aclk),
        .adv     (adv),
        .day     (s_first_day),
        .month   (s_first_month),
        .year    (s_first_year),
        .date_ok (first_ok),
        .ordinal (first_ord)
    );

    dvdd_date_unit u_second (
        .aclk    (aclk),
        .adv     (adv),
        .day     (s_second_day),
        .month   (s_second_month),
        .year    (s_second_year),
        .date_ok (second_ok),
        .ordinal (second_ord)
    );

    // stage 4: status priority is first date, then second date, then ordering
    dvdd_status_t      status_reg, status_next;
    logic [CountW-1:0] count_reg, count_next;

    always_comb begin
        status_next = STATUS_OK;
        count_next  = '0;
        if (!first_ok) begin
            status_next = STATUS_FIRST_BAD;
        end else if (!second_ok) begin
            status_next = STATUS_SECOND_BAD;
        end else if (second_ord < first_ord) begin
            status_next = STATUS_BACKWARD;
        end else begin
            count_next = second_ord - first_ord;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            status_reg <= status_next;
            count_reg  <= count_next;
        end
    end

    assign m_valid     = v4_reg;
    assign m_status    = status_reg;
    assign m_day_count = count_reg;

endmodule

@@ sim/tb_date_validate_day_difference.sv @@
// tb_date_validate_day_difference: self-checking bench for the two-date day difference block
// depends on dvdd_pkg and date_validate_day_difference; predicts status and day count per item

module tb_date_validate_day_difference;
    import dvdd_pkg::*;

    // four pipeline stages; a little slack on top for the tail wait
    localparam int unsigned PipeLatency = 4;
    localparam int unsigned TailCycles  = PipeLatency + 6;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned MaxGap      = 200;

    // expected result of one item
    typedef struct packed {
        dvdd_status_t      status;
        logic [CountW-1:0] day_count;
    } day_diff_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [DayW-1:0]   s_first_day = '0;
    logic [MonthW-1:0] s_first_month = '0;
    logic [YearW-1:0]  s_first_year = '0;
    logic [DayW-1:0]   s_second_day = '0;
    logic [MonthW-1:0] s_second_month = '0;
    logic [YearW-1:0]  s_second_year = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_status;
    logic [CountW-1:0] m_day_count;

    // idle rates in percent, changed per test phase
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;

    day_diff_t   expected_diffs[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    date_validate_day_difference DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_first_day   (s_first_day),
        .s_first_month (s_first_month),
        .s_first_year  (s_first_year),
        .s_second_day  (s_second_day),
        .s_second_month(s_second_month),
        .s_second_year (s_second_year),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_day_count   (m_day_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------

    // 4/100/400 rule
    function automatic bit is_leap(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    // length of a month 1..12 in the given year
    function automatic int unsigned days_in_month(input int unsigned month,
                                                  input int unsigned year);
        case (month)
            4, 6, 9, 11: return 30;
            2:           return is_leap(year) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic bit date_valid(input int unsigned day, input int unsigned month,
                                      input int unsigned year);
        if (year < 1 || year > 9999) return 1'b0;
        if (month < 1 || month > 12) return 1'b0;
        return day >= 1 && day <= days_in_month(month, year);
    endfunction

    // day number counted from 0001-01-01 as day 1; valid dates only
    function automatic int unsigned day_number(input int unsigned day, input int unsigned month,
                                               input int unsigned year);
        int unsigned prior;
        int unsigned total;
        prior = year - 1;
        total = 365 * prior + prior / 4 - prior / 100 + prior / 400;
        for (int unsigned k = 1; k < month; k++) begin
            total += days_in_month(k, year);
        end
        return total + day;
    endfunction

    // status and day count for one item; first date is checked first
    function automatic day_diff_t predict_difference(
        input int unsigned d1, input int unsigned m1, input int unsigned y1,
        input int unsigned d2, input int unsigned m2, input int unsigned y2);
        day_diff_t   r;
        int unsigned from_day;
        int unsigned to_day;
        r.status    = STATUS_OK;
        r.day_count = '0;
        if (!date_valid(d1, m1, y1)) begin
            r.status = STATUS_FIRST_BAD;
        end else if (!date_valid(d2, m2, y2)) begin
            r.status = STATUS_SECOND_BAD;
        end else begin
            from_day = day_number(d1, m1, y1);
            to_day   = day_number(d2, m2, y2);
            if (to_day < from_day) begin
                r.status = STATUS_BACKWARD;
            end else begin
                r.day_count = CountW'(to_day - from_day);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // monitor and scoreboard, both sides sampled at the rising edge
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        day_diff_t want;
        // accepted input item: push its expected result
        if (aresetn && s_valid && s_ready) begin
            expected_diffs.push_back(predict_difference(
                s_first_day, s_first_month, s_first_year,
                s_second_day, s_second_month, s_second_year));
        end
        // accepted result item: compare against the oldest expectation
        if (aresetn && m_valid && m_ready) begin
            if (expected_diffs.size() == 0) begin
                $error("result item with no expectation pending: status %0d, day_count %0d",
                       m_status, m_day_count);
                mismatch_count++;
            end else begin
                want = expected_diffs.pop_front();
                if (m_status !== want.status) begin
                    $error("m_status: expected %0d, got %0d", want.status, m_status);
                    mismatch_count++;
                end
                if (m_day_count !== want.day_count) begin
                    $error("m_day_count: expected %0d, got %0d", want.day_count, m_day_count);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver back-pressure, one draw per cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // present one item after a random idle gap and hold it until accepted;
    // valid is left high so a following item goes out back to back
    task automatic send_dates(
        input logic [DayW-1:0] d1, input logic [MonthW-1:0] m1, input logic [YearW-1:0] y1,
        input logic [DayW-1:0] d2, input logic [MonthW-1:0] m2, input logic [YearW-1:0] y2);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < MaxGap) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_first_day    <= d1;
        s_first_month  <= m1;
        s_first_year   <= y1;
        s_second_day   <= d2;
        s_second_month <= m2;
        s_second_year  <= y2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_diffs.size() != 0);
        repeat (TailCycles) @(posedge aclk);
    endtask

    // a random valid date, weighted toward year extremes, centuries and month ends
    task automatic pick_valid_date(output logic [DayW-1:0] d, output logic [MonthW-1:0] m,
                                   output logic [YearW-1:0] y);
        int unsigned yr;
        int unsigned mo;
        int unsigned len;
        case ($urandom_range(7))
            0:       yr = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(9996, 9999);
            1:       yr = 100 * $urandom_range(1, 99);
            default: yr = $urandom_range(1, 9999);
        endcase
        mo  = $urandom_range(1, 12);
        len = days_in_month(mo, yr);
        d = DayW'(($urandom_range(5) == 0) ? len : $urandom_range(1, len));
        m = MonthW'(mo);
        y = YearW'(yr);
    endtask

    // mostly pairs of valid dates, most in forward order; the rest are raw noise or one broken field
    task automatic run_random_items(input int unsigned count);
        logic [DayW-1:0]   d1, d2;
        logic [MonthW-1:0] m1, m2;
        logic [YearW-1:0]  y1, y2;
        logic [DayW-1:0]   dt;
        logic [MonthW-1:0] mt;
        logic [YearW-1:0]  yt;
        int unsigned       kind;
        for (int unsigned n = 0; n < count; n++) begin
            pick_valid_date(d1, m1, y1);
            pick_valid_date(d2, m2, y2);
            kind = $urandom_range(99);
            // second date close to the first, or the very same date
            if (kind < 25) begin
                y2 = (y1 < 9998) ? y1 + YearW'($urandom_range(2)) : y1;
                if (d2 > days_in_month(m2, y2)) d2 = DayW'(days_in_month(m2, y2));
            end else if (kind < 33) begin
                {d2, m2, y2} = {d1, m1, y1};
            end
            // put most pairs in forward order
            if (day_number(d2, m2, y2) < day_number(d1, m1, y1) && $urandom_range(99) < 85) begin
                {dt, mt, yt} = {d1, m1, y1};
                {d1, m1, y1} = {d2, m2, y2};
                {d2, m2, y2} = {dt, mt, yt};
            end
            if (kind >= 80 && kind < 90) begin
                // raw noise over the full field widths
                d1 = DayW'($urandom);   m1 = MonthW'($urandom); y1 = YearW'($urandom);
                d2 = DayW'($urandom);   m2 = MonthW'($urandom); y2 = YearW'($urandom);
            end else if (kind >= 90) begin
                // break one field of one date (a day drawn for a 31-day month may still be valid)
                case ($urandom_range(5))
                    0: d1 = $urandom_range(1) ? '0 : DayW'($urandom_range(
                               days_in_month(m1, y1) + 1, 31) % 32);
                    1: m1 = $urandom_range(1) ? '0 : MonthW'($urandom_range(13, 15));
                    2: y1 = $urandom_range(1) ? '0 : YearW'($urandom_range(10000, 16383));
                    3: d2 = $urandom_range(1) ? '0 : DayW'($urandom_range(
                               days_in_month(m2, y2) + 1, 31) % 32);
                    4: m2 = $urandom_range(1) ? '0 : MonthW'($urandom_range(13, 15));
                    default: y2 = $urandom_range(1) ? '0 : YearW'($urandom_range(10000, 16383));
                endcase
            end
            send_dates(d1, m1, y1, d2, m2, y2);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, every status and the calendar corner cases
    task automatic test_limits_and_checks();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_dates(1, 1, 1, 31, 12, 9999);          // widest span
        send_dates(1, 1, 1, 1, 1, 1);               // equal dates at the low end
        send_dates(15, 6, 2024, 15, 6, 2024);       // equal dates
        send_dates(2, 1, 2000, 1, 1, 2000);         // second one day earlier
        send_dates(31, 12, 9999, 1, 1, 1);          // backward across the whole range
        send_dates(1, 1, 0, 1, 1, 1);               // year zero
        send_dates(1, 1, 10000, 1, 1, 10000);       // year past 9999
        send_dates(31, 15, 16383, 1, 1, 1);         // first date all ones
        send_dates(1, 0, 2000, 1, 1, 2000);         // month zero
        send_dates(1, 13, 2000, 1, 1, 2001);        // month past twelve
        send_dates(0, 5, 2000, 1, 5, 2000);         // day zero
        send_dates(31, 4, 2001, 1, 5, 2001);        // past the end of april
        send_dates(29, 2, 2000, 29, 2, 2400);       // leap by the 400 rule
        send_dates(29, 2, 1900, 1, 1, 2000);        // century, not leap
        send_dates(28, 2, 2024, 1, 3, 2024);        // across a leap day
        send_dates(1, 1, 2023, 29, 2, 2023);        // second date feb 29 in common year
        send_dates(1, 1, 2023, 1, 0, 2023);         // second month zero
        send_dates(1, 1, 2023, 1, 1, 0);            // second year zero
        send_dates(1, 1, 2023, 0, 1, 2023);         // second day zero
        send_dates(1, 1, 2023, 31, 15, 16383);      // second date all ones
        send_dates(0, 0, 0, 0, 0, 0);               // both dates bad
        send_dates(31, 1, 9999, 31, 12, 9999);      // last year of the range
        send_dates(29, 2, 2024, 28, 2, 2025);       // from a leap day
        drain_results();
    endtask

    // back to back, no idling on either side
    task automatic test_streaming();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_random_items(200);
        drain_results();
    endtask

    // sender mostly idle
    task automatic test_sender_gaps();
        sender_idle_pct    = 87;
        receiver_stall_pct = 0;
        run_random_items(200);
        drain_results();
    endtask

    // receiver mostly stalled, pipeline fills and closes up
    task automatic test_receiver_stalls();
        sender_idle_pct    = 0;
        receiver_stall_pct = 87;
        run_random_items(200);
        drain_results();
    endtask

    // light idling on both sides
    task automatic test_both_idle();
        sender_idle_pct    = 18;
        receiver_stall_pct = 18;
        run_random_items(200);
        drain_results();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_limits_and_checks();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        if (mismatch_count == 0 && expected_diffs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
